>>> sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the one-wire bus master: command kinds,
// bus phases, timing register indexes and reset values, queue sizing.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam int unsigned TW     = 10;
	localparam int unsigned NREGS  = 8;
	localparam int unsigned RAW    = $clog2(NREGS);

	typedef logic [TW-1:0] time_t;

	localparam logic [RAW-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [RAW-1:0] REG_RELEASE_WAIT = 3'd1;
	localparam logic [RAW-1:0] REG_SETTLE       = 3'd2;
	localparam logic [RAW-1:0] REG_SHORT        = 3'd3;
	localparam logic [RAW-1:0] REG_LONG         = 3'd4;
	localparam logic [RAW-1:0] REG_READ_LOW     = 3'd5;
	localparam logic [RAW-1:0] REG_SAMPLE_DELAY = 3'd6;
	localparam logic [RAW-1:0] REG_RECOVERY     = 3'd7;

	localparam time_t REG_RESET_VALS [NREGS] = '{
		10'd480, 10'd30, 10'd15, 10'd15, 10'd45, 10'd2, 10'd10, 10'd60
	};

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_RESET,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_RST_LOW    = 4'd1,
		PH_RST_WAIT   = 4'd2,
		PH_RST_WATCH  = 4'd3,
		PH_RST_SETTLE = 4'd4,
		PH_WR_LOW     = 4'd5,
		PH_WR_HIGH    = 4'd6,
		PH_RD_LOW     = 4'd7,
		PH_RD_WAIT    = 4'd8,
		PH_RD_RECOVER = 4'd9
	} phase_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wdata;
		logic       line;
	} item_t;

	// A zero duration counts as one tick
	function automatic time_t dur(input time_t v);
		dur = (v == '0) ? time_t'(1) : v;
	endfunction

endpackage

>>> sv/owm_front.sv
// ----------------------------------------------------------------------------
// owm_front
// Accepts tick words, decodes the op code into a command kind and holds
// the decoded words in a short queue for the bus sequencer.
// ----------------------------------------------------------------------------
module owm_front
	import owm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [8] line_level
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QAW:0]    count_q;
	item_t           in_item;
	logic            push;

	always_comb begin
		in_item.wdata = s_axis_tdata[7:0];
		in_item.line  = s_axis_tdata[8];
		case (s_axis_tuser)
			OP_RESET: in_item.cmd = CMD_RESET;
			OP_WRITE: in_item.cmd = CMD_WRITE;
			OP_READ:  in_item.cmd = CMD_READ;
			default:  in_item.cmd = CMD_TICK;
		endcase
	end

	assign s_axis_tready = (count_q != (QAW+1)'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign q_item        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/owm_back.sv
// ----------------------------------------------------------------------------
// owm_back
// Bus sequencer: steps the reset, write and read slot phases once per
// queued tick word and registers one result word per tick.
// ----------------------------------------------------------------------------
module owm_back
	import owm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [RAW-1:0] cfg_addr,
	input  time_t          cfg_data,
	input  logic           q_valid,
	input  item_t          q_item,
	output logic           q_pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [15:0]    m_axis_tdata   // [0] pull_low, [1] busy_res, [2] done_res,
	                                      // [10:3] read_data
);

	time_t      regs_q [NREGS];
	phase_t     phase_q;
	time_t      time_left_q;
	logic [2:0] bit_q;
	logic [7:0] send_q;
	logic [7:0] recv_q;
	logic       out_valid_q;
	logic [15:0] out_data_q;

	phase_t     ph;
	time_t      tl;
	logic [2:0] bi;
	logic [7:0] ss;
	logic [7:0] rs;
	logic       pull;
	logic       busy;
	logic       done;
	logic       ends;
	time_t      tl_dec;

	assign q_pop = q_valid && (!out_valid_q || m_axis_tready);

	always_comb begin
		ph   = phase_q;
		tl   = time_left_q;
		bi   = bit_q;
		ss   = send_q;
		rs   = recv_q;
		pull = 1'b0;
		busy = 1'b0;
		done = 1'b0;

		if (ph == PH_IDLE) begin
			case (q_item.cmd)
				CMD_RESET: begin
					ph = PH_RST_LOW;
					tl = dur(regs_q[REG_RESET_LOW]);
				end
				CMD_WRITE: begin
					ss = q_item.wdata;
					bi = '0;
					ph = PH_WR_LOW;
					tl = dur(q_item.wdata[0] ? regs_q[REG_SHORT] : regs_q[REG_LONG]);
				end
				CMD_READ: begin
					bi = '0;
					ph = PH_RD_LOW;
					tl = dur(regs_q[REG_READ_LOW]);
				end
				default: ;
			endcase
		end

		ends   = (tl <= time_t'(1));
		tl_dec = ends ? '0 : tl - 1'b1;

		if (ph != PH_IDLE) begin
			busy = 1'b1;
		end

		case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				pull = 1'b1;
				if (ends) begin
					ph = PH_RST_WAIT;
					tl = dur(regs_q[REG_RELEASE_WAIT]);
				end else begin
					tl = tl_dec;
				end
			end
			PH_RST_WAIT: begin
				if (ends) begin
					ph = PH_RST_WATCH;
				end
				tl = tl_dec;
			end
			PH_RST_WATCH: begin
				// wait for the presence pulse to end, no timeout
				if (q_item.line) begin
					ph = PH_RST_SETTLE;
					tl = dur(regs_q[REG_SETTLE]);
				end
			end
			PH_RST_SETTLE: begin
				tl = tl_dec;
				if (ends) begin
					ph   = PH_IDLE;
					done = 1'b1;
				end
			end
			PH_WR_LOW: begin
				pull = 1'b1;
				if (ends) begin
					ph = PH_WR_HIGH;
					tl = dur(ss[0] ? regs_q[REG_LONG] : regs_q[REG_SHORT]);
				end else begin
					tl = tl_dec;
				end
			end
			PH_WR_HIGH: begin
				tl = tl_dec;
				if (ends) begin
					ss = {1'b0, ss[7:1]};
					bi = bi + 1'b1;
					if (bi == '0) begin
						ph   = PH_IDLE;
						done = 1'b1;
					end else begin
						ph = PH_WR_LOW;
						tl = dur(ss[0] ? regs_q[REG_SHORT] : regs_q[REG_LONG]);
					end
				end
			end
			PH_RD_LOW: begin
				pull = 1'b1;
				if (ends) begin
					ph = PH_RD_WAIT;
					tl = dur(regs_q[REG_SAMPLE_DELAY]);
				end else begin
					tl = tl_dec;
				end
			end
			PH_RD_WAIT: begin
				if (ends) begin
					// sample on the last tick of the wait, shift in at the top
					rs = {q_item.line, rs[7:1]};
					ph = PH_RD_RECOVER;
					tl = dur(regs_q[REG_RECOVERY]);
				end else begin
					tl = tl_dec;
				end
			end
			PH_RD_RECOVER: begin
				tl = tl_dec;
				if (ends) begin
					bi = bi + 1'b1;
					if (bi == '0) begin
						ph   = PH_IDLE;
						done = 1'b1;
					end else begin
						ph = PH_RD_LOW;
						tl = dur(regs_q[REG_READ_LOW]);
					end
				end
			end
			default: begin
				ph   = PH_IDLE;
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				regs_q[i] <= REG_RESET_VALS[i];
			end
		end else if (cfg_we) begin
			regs_q[cfg_addr] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			time_left_q <= '0;
			bit_q       <= '0;
			send_q      <= '0;
			recv_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= ph;
				time_left_q <= tl;
				bit_q       <= bi;
				send_q      <= ss;
				recv_q      <= rs;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= {5'b0, rs, done, busy, pull};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && done) |=> (phase_q == PH_IDLE))
		else $error("command finished but sequencer not idle");

	a_watch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && phase_q == PH_RST_WATCH && !q_item.line) |=> (phase_q == PH_RST_WATCH))
		else $error("reset watch left while line low");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!q_pop |=> ($stable(phase_q) && $stable(bit_q) && $stable(recv_q)))
		else $error("sequencer state moved without a tick");

	a_busy_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && done) |=> (m_axis_tdata[1] && m_axis_tvalid))
		else $error("done result without busy");

endmodule

>>> sv/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one tick word per microsecond: reset
// pulse with presence watch, byte write and byte read, LSB first.
// ----------------------------------------------------------------------------
// Path: a tick word waits in the input queue, then the sequencer steps it
// into a result word in its output register. Throughput: one tick word
// per cycle unless the output stalls; the sequencer steps once per word.
// Reset: timing registers return to their defaults, sequencer idle, queue
// and output register empty.
module one_wire_bus_master
	import owm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [15:0]    s_axis_tdata,   // [7:0] write_data, [8] line_level
	input  logic [1:0]     s_axis_tuser,   // [1:0] op
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [15:0]    m_axis_tdata,   // [0] pull_low, [1] busy_res, [2] done_res,
	                                       // [10:3] read_data
	input  logic           cfg_we,
	input  logic [RAW-1:0] cfg_addr,
	input  time_t          cfg_data
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	owm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	owm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> tb/one_wire_bus_master_test.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_test
// Self-checking bench for the one-wire bus master. Tick words go in on the
// input stream and a scoreboard steps its own model of the bus sequencer once
// per accepted word. It then compares every result word with the oldest
// prediction. The run covers the reset timing and several programmed timing
// sets, among them zero-valued and all-ones registers, in several idling modes.
// ----------------------------------------------------------------------------
module one_wire_bus_master_test;
	import owm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned GAP_PCT [4]   = '{0, 74, 0, 36};
	localparam int unsigned STALL_PCT [4] = '{0, 0, 74, 36};

	typedef struct packed {
		logic [7:0] rdata;
		logic       done;
		logic       busy;
		logic       pull;
	} bus_word_t;

	// Steps a model of the sequencer on each accepted tick word and holds
	// the result words still owed by the block
	class owm_scoreboard;
		phase_t      seq_phase;
		time_t       ticks_left;
		logic [2:0]  bit_no;
		logic [7:0]  tx_shift;
		logic [7:0]  rx_shift;
		time_t       timing [NREGS];
		bus_word_t   expected_words [$];
		int unsigned mismatches;

		function new();
			foreach (timing[i])
				timing[i] = REG_RESET_VALS[i];
			seq_phase  = PH_IDLE;
			ticks_left = '0;
			bit_no     = '0;
			tx_shift   = '0;
			rx_shift   = '0;
			mismatches = 0;
		endfunction

		function void set_timing(int unsigned idx, time_t v);
			timing[idx] = v;
		endfunction

		function void enter_phase(phase_t p, time_t d);
			seq_phase  = p;
			ticks_left = (d == '0) ? time_t'(1) : d;
		endfunction

		function bit phase_over();
			if (ticks_left <= time_t'(1)) begin
				ticks_left = '0;
				return 1'b1;
			end
			ticks_left = ticks_left - time_t'(1);
			return 1'b0;
		endfunction

		function void absorb_tick(cmd_t cmd, logic [7:0] wdata, logic line);
			bus_word_t r;
			r = '0;
			if (seq_phase == PH_IDLE) begin
				case (cmd)
					CMD_RESET: enter_phase(PH_RST_LOW, timing[REG_RESET_LOW]);
					CMD_WRITE: begin
						tx_shift = wdata;
						bit_no   = '0;
						enter_phase(PH_WR_LOW,
							tx_shift[0] ? timing[REG_SHORT] : timing[REG_LONG]);
					end
					CMD_READ: begin
						bit_no = '0;
						enter_phase(PH_RD_LOW, timing[REG_READ_LOW]);
					end
					default: ;
				endcase
			end
			if (seq_phase != PH_IDLE) begin
				r.busy = 1'b1;
				case (seq_phase)
					PH_RST_LOW: begin
						r.pull = 1'b1;
						if (phase_over())
							enter_phase(PH_RST_WAIT, timing[REG_RELEASE_WAIT]);
					end
					PH_RST_WAIT: begin
						if (phase_over()) begin
							seq_phase  = PH_RST_WATCH;
							ticks_left = '0;
						end
					end
					// no timeout: hold here until the line reads high
					PH_RST_WATCH: begin
						if (line)
							enter_phase(PH_RST_SETTLE, timing[REG_SETTLE]);
					end
					PH_RST_SETTLE: begin
						if (phase_over()) begin
							seq_phase = PH_IDLE;
							r.done    = 1'b1;
						end
					end
					PH_WR_LOW: begin
						r.pull = 1'b1;
						if (phase_over())
							enter_phase(PH_WR_HIGH,
								tx_shift[0] ? timing[REG_LONG] : timing[REG_SHORT]);
					end
					PH_WR_HIGH: begin
						if (phase_over()) begin
							tx_shift = tx_shift >> 1;
							bit_no   = bit_no + 3'd1;
							if (bit_no == 3'd0) begin
								seq_phase = PH_IDLE;
								r.done    = 1'b1;
							end else begin
								enter_phase(PH_WR_LOW,
									tx_shift[0] ? timing[REG_SHORT] : timing[REG_LONG]);
							end
						end
					end
					PH_RD_LOW: begin
						r.pull = 1'b1;
						if (phase_over())
							enter_phase(PH_RD_WAIT, timing[REG_SAMPLE_DELAY]);
					end
					// sample on the last tick of the wait, entering at bit 7
					PH_RD_WAIT: begin
						if (phase_over()) begin
							rx_shift = {line, rx_shift[7:1]};
							enter_phase(PH_RD_RECOVER, timing[REG_RECOVERY]);
						end
					end
					PH_RD_RECOVER: begin
						if (phase_over()) begin
							bit_no = bit_no + 3'd1;
							if (bit_no == 3'd0) begin
								seq_phase = PH_IDLE;
								r.done    = 1'b1;
							end else begin
								enter_phase(PH_RD_LOW, timing[REG_READ_LOW]);
							end
						end
					end
					default: begin
						seq_phase = PH_IDLE;
						r.busy    = 1'b0;
					end
				endcase
			end
			r.rdata = rx_shift;
			expected_words.push_back(r);
		endfunction

		function void match_result(logic [15:0] word);
			bus_word_t got;
			bus_word_t want;
			got = word[10:0];
			if (expected_words.size() == 0) begin
				$display("%0t: result word %h with nothing expected", $time, word);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			if (got.pull !== want.pull) begin
				$display("%0t: pull_low expected %0d actual %0d", $time, want.pull, got.pull);
				mismatches++;
			end
			if (got.busy !== want.busy) begin
				$display("%0t: busy expected %0d actual %0d", $time, want.busy, got.busy);
				mismatches++;
			end
			if (got.done !== want.done) begin
				$display("%0t: done expected %0d actual %0d", $time, want.done, got.done);
				mismatches++;
			end
			if (got.rdata !== want.rdata) begin
				$display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [15:0]    s_axis_tdata = '0;   // [7:0] write_data, [8] line_level
	logic [1:0]     s_axis_tuser = '0;   // [1:0] op
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [15:0]    m_axis_tdata;        // [0] pull_low, [1] busy, [2] done, [10:3] read_data
	logic           cfg_we = 1'b0;
	logic [RAW-1:0] cfg_addr = '0;
	time_t          cfg_data = '0;

	owm_scoreboard sb = new();
	int unsigned   gap_pct = 0;
	int unsigned   stall_pct = 0;
	int unsigned   hold_off = 0;
	int unsigned   quiet = 0;

	one_wire_bus_master u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.absorb_tick(cmd_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8]);
			if (m_axis_tvalid && m_axis_tready)
				sb.match_result(m_axis_tdata);
		end
	end

	// Hold off for a counted stretch when asked, else stall at random
	always @(posedge clk) begin
		if (hold_off != 0) begin
			hold_off--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input cmd_t op, input logic [7:0] wdata, input logic line);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, line, wdata};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Half plain ticks; commands land whenever the sequencer is idle
	task automatic random_word();
		int unsigned r;
		cmd_t        op;
		r = $urandom_range(0, 9);
		if (r < 5)
			op = CMD_TICK;
		else if (r == 5)
			op = CMD_RESET;
		else if (r < 8)
			op = CMD_WRITE;
		else
			op = CMD_READ;
		send_word(op, 8'($urandom), 1'($urandom));
	endtask

	// Drop valid, wait for every owed word, then let the pipeline empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_timing(input time_t vals [NREGS]);
		for (int i = 0; i < NREGS; i++) begin
			cfg_we   <= 1'b1;
			cfg_addr <= RAW'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_timing(i, vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic time_t pick_time();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return time_t'($urandom_range(9, 40));
		return time_t'($urandom_range(1, 8));
	endfunction

	initial begin
		time_t cfg [NREGS];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle words at the field extremes, then a read slot at reset timing
		send_word(CMD_TICK, 8'h00, 1'b0);
		send_word(CMD_TICK, 8'hFF, 1'b1);
		send_word(CMD_READ, 8'h5A, 1'b0);
		repeat (14) send_word(CMD_TICK, 8'h00, 1'b1);
		wait_drained();

		// reprogram mid-read: the new values apply from the next phase loaded
		cfg = '{10'd3, 10'd2, 10'd1, 10'd0, 10'd4, 10'd1, 10'd2, 10'd0};
		program_timing(cfg);
		repeat (40) send_word(CMD_TICK, 8'($urandom), 1'($urandom));
		send_word(CMD_WRITE, 8'hC3, 1'b0);
		repeat (50) send_word(CMD_TICK, 8'($urandom), 1'($urandom));

		// reset pulse with the line held low through the watch for a while
		send_word(CMD_RESET, 8'h00, 1'b0);
		repeat (12) send_word(CMD_TICK, 8'hFF, 1'b0);
		send_word(CMD_TICK, 8'h00, 1'b1);
		repeat (3) send_word(CMD_TICK, 8'h00, 1'b0);
		send_word(CMD_WRITE, 8'hFF, 1'b1);
		repeat (42) send_word(CMD_TICK, 8'h00, 1'b1);
		send_word(CMD_WRITE, 8'h00, 1'b0);
		repeat (42) send_word(CMD_TICK, 8'hFF, 1'b0);
		wait_drained();

		// every register at full scale, then cut back while the pulse is low
		foreach (cfg[i])
			cfg[i] = '1;
		program_timing(cfg);
		send_word(CMD_RESET, 8'hFF, 1'b1);
		repeat (20) send_word(CMD_TICK, 8'($urandom), 1'($urandom));
		wait_drained();
		foreach (cfg[i])
			cfg[i] = pick_time();
		program_timing(cfg);
		repeat (20) random_word();

		for (int m = 0; m < 4; m++) begin
			wait_drained();
			gap_pct   = GAP_PCT[m];
			stall_pct = STALL_PCT[m];
			foreach (cfg[i])
				cfg[i] = pick_time();
			program_timing(cfg);
			// back up the output with the sender still offering words
			if (m == 0)
				hold_off = 60;
			repeat (200) random_word();
		end

		gap_pct   = 0;
		stall_pct = 0;
		wait_drained();
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
